[rtl/wafl_pkg.sv]
// ----------------------------------------------------------------------------
// wafl_pkg
// shared types and constants of the watermark allocator with free table
// ----------------------------------------------------------------------------
`default_nettype none

package wafl_pkg;

	localparam int ADDR_W = 48;
	localparam int SIZE_W = 32;
	localparam int RSIZE_W = SIZE_W + 1;     // rounded size can carry one bit
	localparam int FREE_ENTRIES_DEF = 16;

	// allocation granule, a power of two
	localparam int ALIGN_BYTES = 64;
	localparam logic [RSIZE_W-1:0] ALIGN_ADD = RSIZE_W'(ALIGN_BYTES - 1);
	localparam logic [RSIZE_W-1:0] ALIGN_MASK = ~ALIGN_ADD;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_RESET = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD      = 2'd0,
		CELL_FROM_NEXT = 2'd1,
		CELL_FROM_PREV = 2'd2,
		CELL_LOAD      = 2'd3
	} wafl_cell_op_t;

	typedef struct packed {
		wafl_cell_op_t     op;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
	} wafl_cell_ctl_t;

endpackage

`default_nettype wire

[rtl/wafl_cell.sv]
// ----------------------------------------------------------------------------
// wafl_cell
// one free table entry; shifts to or from its neighbors, or loads new data
// ----------------------------------------------------------------------------
`default_nettype none

module wafl_cell
	import wafl_pkg::*;
(
	input  wire logic              clk,
	input  wire wafl_cell_ctl_t    ctl,
	input  wire logic [ADDR_W-1:0] prev_base,
	input  wire logic [ADDR_W-1:0] prev_len,
	input  wire logic [ADDR_W-1:0] next_base,
	input  wire logic [ADDR_W-1:0] next_len,
	output logic      [ADDR_W-1:0] base,
	output logic      [ADDR_W-1:0] len
);

	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] len_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_FROM_NEXT: begin
				base_q <= next_base;
				len_q  <= next_len;
			end
			CELL_FROM_PREV: begin
				base_q <= prev_base;
				len_q  <= prev_len;
			end
			CELL_LOAD: begin
				base_q <= ctl.base;
				len_q  <= ctl.len;
			end
			default: begin
				base_q <= base_q;
				len_q  <= len_q;
			end
		endcase
	end

	assign base = base_q;
	assign len  = len_q;

endmodule

`default_nettype wire

[rtl/watermark_allocator_free_list.sv]
// ----------------------------------------------------------------------------
// watermark_allocator_free_list
// bump allocator backed by an address-sorted first-fit table of free extents
// ----------------------------------------------------------------------------
// usage:
//   s_* carries request words (action, request_size, block_address); m_* returns
//   one response word (granted_address, status) per request, in order.
//   wr_en/wr_index/wr_data set region_base (index 0, also rewinds the
//   watermark) and region_size (index 1); write only while the block is idle.
//   sizes round up to 64 bytes. an allocate scans the table cells one per
//   cycle for the first fit, removing it whole; on a miss it bumps the
//   watermark or reports out of memory. a free scans for its sorted place,
//   then merges with neighbors or inserts, shifting the cell chain in the commit state.
// sequencing:
//   one word at a time. allocate/free: accept, a scan of the held extents
//   (at most FREE_ENTRIES) up to the first fit or the sorted place, commit,
//   then response. reset and unused actions: accept, then response.
//   the scan is set by the single compare port walking the cell chain.
// reset: arst_n clears control, watermark, region registers and extent count;
//   table contents stay undefined until written.
// stall: the response register holds while m_tready is low; the next request
//   may be taken and scanned meanwhile, it waits only to hand over its result.
// ----------------------------------------------------------------------------
`default_nettype none

module watermark_allocator_free_list
	import wafl_pkg::*;
#(
	parameter int FREE_ENTRIES = FREE_ENTRIES_DEF
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [47:0] wr_data,
	// request words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,  // action[1:0], request_size[33:2], block_address[81:34]
	// response words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata   // granted_address[47:0], status[49:48]
);

	localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CW = $clog2(FREE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_ENTRIES);
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_COMMIT = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	state_t            state_q;
	logic [1:0]        act_q;
	logic [RSIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              hit_q;
	logic [ADDR_W-1:0] prev_base_q;
	logic [ADDR_W-1:0] prev_len_q;
	logic [ADDR_W-1:0] wm_q;
	logic [ADDR_W-1:0] region_base_q;
	logic [ADDR_W-1:0] region_size_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [1:0]        out_status_q;

	// cell chain
	logic [ADDR_W-1:0] cell_base [FREE_ENTRIES];
	logic [ADDR_W-1:0] cell_len  [FREE_ENTRIES];
	wafl_cell_ctl_t    cell_ctl  [FREE_ENTRIES];

	for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_cell
		logic [ADDR_W-1:0] pb, pl, nb, nl;
		if (g == 0) begin : g_first
			assign pb = '0;
			assign pl = '0;
		end else begin : g_mid_prev
			assign pb = cell_base[g-1];
			assign pl = cell_len[g-1];
		end
		if (g == FREE_ENTRIES - 1) begin : g_last
			assign nb = '0;
			assign nl = '0;
		end else begin : g_mid_next
			assign nb = cell_base[g+1];
			assign nl = cell_len[g+1];
		end
		wafl_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[g]),
			.prev_base (pb),
			.prev_len  (pl),
			.next_base (nb),
			.next_len  (nl),
			.base      (cell_base[g]),
			.len       (cell_len[g])
		);
	end

	// input word fields
	logic [1:0]         in_action;
	logic [SIZE_W-1:0]  in_size;
	logic [ADDR_W-1:0]  in_addr;
	logic [RSIZE_W-1:0] in_size_rnd;
	assign in_action   = s_tdata[1:0];
	assign in_size     = s_tdata[33:2];
	assign in_addr     = s_tdata[81:34];
	assign in_size_rnd = ({1'b0, in_size} + ALIGN_ADD) & ALIGN_MASK;

	// entry under the scan pointer
	logic [ADDR_W-1:0] cur_base, cur_len, sz48;
	logic              at_end;
	assign cur_base = cell_base[idx_q[IW-1:0]];
	assign cur_len  = cell_len[idx_q[IW-1:0]];
	assign at_end   = (idx_q == count_q);
	assign sz48     = ADDR_W'(size_q);

	// bump check
	logic [ADDR_W:0] bump_end, region_end;
	logic            oom;
	assign bump_end   = {1'b0, wm_q} + {1'b0, sz48};
	assign region_end = {1'b0, region_base_q} + {1'b0, region_size_q};
	assign oom        = (bump_end > region_end) || bump_end[ADDR_W];

	// merge checks and saturated sums
	logic [ADDR_W:0]   next_end, prev_end;
	logic [ADDR_W+1:0] sum_both;
	logic [ADDR_W:0]   sum_prev, sum_next;
	logic              mnext, mprev;
	logic [ADDR_W-1:0] len_both, len_prev, len_next;
	assign next_end = {1'b0, addr_q} + {1'b0, sz48};
	assign prev_end = {1'b0, prev_base_q} + {1'b0, prev_len_q};
	assign mnext    = !at_end && (next_end == {1'b0, cur_base});
	assign mprev    = (idx_q != '0) && (prev_end == {1'b0, addr_q});
	assign sum_both = {2'b0, prev_len_q} + {2'b0, sz48} + {2'b0, cur_len};
	assign sum_prev = {1'b0, prev_len_q} + {1'b0, sz48};
	assign sum_next = {1'b0, sz48} + {1'b0, cur_len};
	assign len_both = (sum_both[ADDR_W+1:ADDR_W] != 2'b0) ? ADDR_MAX : sum_both[ADDR_W-1:0];
	assign len_prev = sum_prev[ADDR_W] ? ADDR_MAX : sum_prev[ADDR_W-1:0];
	assign len_next = sum_next[ADDR_W] ? ADDR_MAX : sum_next[ADDR_W-1:0];

	logic [CW-1:0] idx_m1;
	assign idx_m1 = idx_q - CW'(1);

	// per-cell commands, only during commit
	always_comb begin
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			cell_ctl[i].op   = CELL_HOLD;
			cell_ctl[i].base = '0;
			cell_ctl[i].len  = '0;
			if (state_q == S_COMMIT) begin
				if (act_q == ACT_ALLOC) begin
					// remove the fitting entry, close the gap
					if (hit_q && CW'(i) >= idx_q)
						cell_ctl[i].op = CELL_FROM_NEXT;
				end else if (mnext && mprev) begin
					if (CW'(i) == idx_m1) begin
						cell_ctl[i].op   = CELL_LOAD;
						cell_ctl[i].base = prev_base_q;
						cell_ctl[i].len  = len_both;
					end else if (CW'(i) >= idx_q) begin
						cell_ctl[i].op = CELL_FROM_NEXT;
					end
				end else if (mprev) begin
					if (CW'(i) == idx_m1) begin
						cell_ctl[i].op   = CELL_LOAD;
						cell_ctl[i].base = prev_base_q;
						cell_ctl[i].len  = len_prev;
					end
				end else if (mnext) begin
					if (CW'(i) == idx_q) begin
						cell_ctl[i].op   = CELL_LOAD;
						cell_ctl[i].base = addr_q;
						cell_ctl[i].len  = len_next;
					end
				end else if (count_q != FULL_COUNT) begin
					// open a slot at the scan point
					if (CW'(i) == idx_q) begin
						cell_ctl[i].op   = CELL_LOAD;
						cell_ctl[i].base = addr_q;
						cell_ctl[i].len  = sz48;
					end else if (CW'(i) > idx_q) begin
						cell_ctl[i].op = CELL_FROM_PREV;
					end
				end
			end
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			wm_q          <= '0;
			region_base_q <= '0;
			region_size_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// response register: load from the response state, else clear on take
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (wr_en) begin
				if (wr_index == 1'b0) begin
					region_base_q <= wr_data;
					wm_q          <= wr_data;
				end else begin
					region_size_q <= wr_data;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q        <= in_action;
						size_q       <= in_size_rnd;
						addr_q       <= in_addr;
						idx_q        <= '0;
						hit_q        <= 1'b0;
						res_addr_q   <= '0;
						res_status_q <= ST_OK;
						if (in_action == ACT_ALLOC || in_action == ACT_FREE) begin
							state_q <= S_SCAN;
						end else begin
							if (in_action == ACT_RESET)
								wm_q <= region_base_q;
							state_q <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (act_q == ACT_ALLOC) begin
						if (at_end) begin
							state_q <= S_COMMIT;
						end else if (cur_len >= sz48) begin
							hit_q   <= 1'b1;
							state_q <= S_COMMIT;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else begin
						if (at_end || cur_base >= addr_q) begin
							state_q <= S_COMMIT;
						end else begin
							prev_base_q <= cur_base;
							prev_len_q  <= cur_len;
							idx_q       <= idx_q + CW'(1);
						end
					end
				end
				S_COMMIT: begin
					state_q <= S_RESP;
					if (act_q == ACT_ALLOC) begin
						if (hit_q) begin
							res_addr_q <= cur_base;
							count_q    <= count_q - CW'(1);
						end else if (oom) begin
							res_status_q <= ST_OOM;
						end else begin
							res_addr_q <= wm_q;
							wm_q       <= bump_end[ADDR_W-1:0];
						end
					end else if (mnext && mprev) begin
						count_q <= count_q - CW'(1);
					end else if (!mnext && !mprev) begin
						if (count_q == FULL_COUNT)
							res_status_q <= ST_FULL;
						else
							count_q <= count_q + CW'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_status_q, out_addr_q};

endmodule

`default_nettype wire

[rtl/wafl_checker.sv]
// ----------------------------------------------------------------------------
// wafl_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wafl_checker
	import wafl_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata
);

	// a held response stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("response dropped while stalled");

	// one request at a time: ready drops after a take
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[49:48] != 2'd3)
		else $error("bad status code");

	// failures grant nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[49:48] != ST_OK |-> m_tdata[47:0] == 48'd0)
		else $error("nonzero address on failure");

endmodule

bind watermark_allocator_free_list wafl_checker u_wafl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the watermark allocator with first-fit free table
// ----------------------------------------------------------------------------
// drives request words in random bursts, stalls the response side on its own
// pattern, and compares every response word with a typed grant or a local
// allocator model tracking watermark, region registers and the sorted free table
// ----------------------------------------------------------------------------

module testbench;
	import wafl_pkg::*;

	localparam int NFREE = FREE_ENTRIES_DEF;
	localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int RAND_WORDS = 1200;
	localparam int IDX_BASE = 0;
	localparam int IDX_SIZE = 1;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic wr_index;
	logic [47:0] wr_data;
	logic s_tvalid;
	logic s_tready;
	logic [87:0] s_tdata;   // action[1:0], request_size[33:2], block_address[81:34]
	logic m_tvalid;
	logic m_tready;
	logic [55:0] m_tdata;   // granted_address[47:0], status[49:48]

	watermark_allocator_free_list u_top (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ---------------- allocator model ----------------
	typedef struct packed {
		logic [47:0] addr;
		logic [1:0]  status;
	} grant_t;

	logic [47:0] mdl_base, mdl_size, mdl_wmark;
	logic [47:0] ext_base [NFREE];
	logic [47:0] ext_len [NFREE];
	int ext_cnt;
	grant_t pending_grants[$];
	int errors = 0;
	bit hold_off = 0;

	function automatic logic [47:0] sat_add(logic [49:0] v);
		return (v > 50'(ADDR_MAX)) ? ADDR_MAX : v[47:0];
	endfunction

	// removes table entry i, shifting the rest down
	function automatic void drop_extent(int i);
		for (int k = i; k + 1 < ext_cnt; k++) begin
			ext_base[k] = ext_base[k+1];
			ext_len[k] = ext_len[k+1];
		end
		ext_cnt--;
	endfunction

	function automatic grant_t predict_grant(logic [1:0] act, logic [31:0] sz, logic [47:0] ad);
		grant_t g;
		logic [47:0] rsz;
		logic [49:0] fin, lim;
		int i;
		bit mn, mp, hit;
		g = '0;
		rsz = ((48'(sz) + 48'd63) >> 6) << 6;
		if (act == ACT_ALLOC) begin
			hit = 0;
			for (i = 0; i < ext_cnt && !hit; i++)
				if (ext_len[i] >= rsz) begin
					g.addr = ext_base[i];
					drop_extent(i);
					hit = 1;
				end
			if (!hit) begin
				fin = 50'(mdl_wmark) + 50'(rsz);
				lim = 50'(mdl_base) + 50'(mdl_size);
				if (fin > lim || fin > 50'(ADDR_MAX))
					g.status = ST_OOM;
				else begin
					g.addr = mdl_wmark;
					mdl_wmark = fin[47:0];
				end
			end
		end else if (act == ACT_FREE) begin
			i = 0;
			while (i < ext_cnt && ext_base[i] < ad)
				i++;
			// extent ends are compared without wrapping past the address space
			mn = (i < ext_cnt) && ((49'(ad) + 49'(rsz)) == 49'(ext_base[i]));
			mp = (i > 0) && ((49'(ext_base[i-1]) + 49'(ext_len[i-1])) == 49'(ad));
			if (mn && mp) begin
				ext_len[i-1] = sat_add(50'(ext_len[i-1]) + 50'(rsz) + 50'(ext_len[i]));
				drop_extent(i);
			end else if (mp)
				ext_len[i-1] = sat_add(50'(ext_len[i-1]) + 50'(rsz));
			else if (mn) begin
				ext_base[i] = ad;
				ext_len[i] = sat_add(50'(rsz) + 50'(ext_len[i]));
			end else if (ext_cnt >= NFREE)
				g.status = ST_FULL;
			else begin
				for (int k = ext_cnt; k > i; k--) begin
					ext_base[k] = ext_base[k-1];
					ext_len[k] = ext_len[k-1];
				end
				ext_base[i] = ad;
				ext_len[i] = rsz;
				ext_cnt++;
			end
		end else if (act == ACT_RESET)
			mdl_wmark = mdl_base;
		return g;
	endfunction

	// ---------------- response checker ----------------
	always @(posedge clk) begin
		grant_t want;
		if (m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected response word %h", m_tdata);
				errors++;
			end else begin
				want = pending_grants.pop_front();
				if (m_tdata[47:0] !== want.addr) begin
					$error("granted_address expected %h actual %h", want.addr, m_tdata[47:0]);
					errors++;
				end
				if (m_tdata[49:48] !== want.status) begin
					$error("status expected %0d actual %0d", want.status, m_tdata[49:48]);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			case ($urandom_range(0, 3))
				0: m_tready <= 1'b0;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= 1'b1;
			endcase
		end
	end

	// ---------------- stimulus ----------------
	int burst_left = 0;
	bit mixed_idle = 1;

	// one request word, sender gaps in bursts; the prediction is made on acceptance
	task automatic send_word(logic [1:0] act, logic [31:0] sz, logic [47:0] ad,
			bit fixed, grant_t fixed_grant);
		grant_t g;
		int gap;
		if (mixed_idle && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, ad, sz, act};
		do @(posedge clk); while (!s_tready);
		g = predict_grant(act, sz, ad);
		// directed rows check against the typed value, the rest against the model
		pending_grants.push_back(fixed ? fixed_grant : g);
		if (burst_left > 0) burst_left--;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (NFREE + 8) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [47:0] val);
		wr_en <= 1'b1;
		wr_index <= idx[0];
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == IDX_BASE) begin
			mdl_base = val;
			mdl_wmark = val;
		end else
			mdl_size = val;
	endtask

	typedef struct {
		logic [1:0]  act;
		logic [31:0] sz;
		logic [47:0] ad;
		bit          fixed;
		grant_t      grant;
	} row_t;

	row_t dir_rows[$];

	function automatic row_t mk(logic [1:0] a, logic [31:0] s, logic [47:0] d,
			bit f = 0, logic [47:0] ga = 0, logic [1:0] st = ST_OK);
		row_t r;
		r.act = a; r.sz = s; r.ad = d; r.fixed = f;
		r.grant.addr = ga; r.grant.status = st;
		return r;
	endfunction

	// allocation sequence in a region with random content
	task automatic random_phase(int words);
		logic [47:0] lives[$];
		logic [31:0] sz;
		int pick;
		for (int n = 0; n < words; n++) begin
			if (n == words / 3) hold_off = 1;
			if (n == words / 2) drain();
			case ($urandom_range(0, 19))
				0,1,2,3,4,5,6,7: begin
					sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1024);
					send_word(ACT_ALLOC, sz, 48'($urandom), 0, '0);
					if (pending_grants[$].status == ST_OK && lives.size() < 64)
						lives.push_back(pending_grants[$].addr);
				end
				8,9,10,11,12,13,14: begin
					if (lives.size() != 0) begin
						pick = $urandom_range(0, lives.size() - 1);
						send_word(ACT_FREE, $urandom_range(0, 512), lives[pick], 0, '0);
						lives.delete(pick);
					end else
						send_word(ACT_FREE, $urandom_range(0, 256),
							mdl_base + 48'($urandom_range(0, 4096) * 64), 0, '0);
				end
				15: send_word(ACT_FREE, $urandom, 48'({$urandom, $urandom}), 0, '0);
				16: send_word(ACT_RESET, $urandom, 48'({$urandom, $urandom}), 0, '0);
				17: send_word(2'd3, $urandom, 48'({$urandom, $urandom}), 0, '0);
				default: send_word(ACT_ALLOC, 0, 0, 0, '0);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = 1'b0;
		wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mdl_base = '0;
		mdl_size = '0;
		mdl_wmark = '0;
		ext_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the region is empty: zero size grants the watermark, else oom
		dir_rows.push_back(mk(ACT_ALLOC, 0, 0, 1, 0, ST_OK));
		dir_rows.push_back(mk(ACT_ALLOC, 1, 0, 1, 0, ST_OOM));
		dir_rows.push_back(mk(2'd3, 32'hFFFF_FFFF, ADDR_MAX, 1, 0, ST_OK));
		dir_rows.push_back(mk(ACT_RESET, 0, 0, 1, 0, ST_OK));
		foreach (dir_rows[i])
			send_word(dir_rows[i].act, dir_rows[i].sz, dir_rows[i].ad, 1, dir_rows[i].grant);
		drain();
		dir_rows.delete();

		write_reg(IDX_BASE, 48'h1000);
		write_reg(IDX_SIZE, 48'h10000);
		dir_rows.push_back(mk(ACT_ALLOC, 1, 0, 1, 48'h1000));
		dir_rows.push_back(mk(ACT_ALLOC, 64, 0, 1, 48'h1040));
		dir_rows.push_back(mk(ACT_ALLOC, 65, 0));
		dir_rows.push_back(mk(ACT_ALLOC, 32'hFFFF_FFFF, 0, 1, 0, ST_OOM));
		dir_rows.push_back(mk(ACT_FREE, 64, 48'h1040));     // new entry
		dir_rows.push_back(mk(ACT_FREE, 64, 48'h1000));     // merge with next
		dir_rows.push_back(mk(ACT_FREE, 128, 48'h1080));    // merge with previous
		dir_rows.push_back(mk(ACT_FREE, 64, 48'h2000));
		dir_rows.push_back(mk(ACT_FREE, 64, 48'h2080));
		dir_rows.push_back(mk(ACT_FREE, 64, 48'h2040));     // merge both sides
		dir_rows.push_back(mk(ACT_FREE, 64, 48'h2000));     // equal base
		dir_rows.push_back(mk(ACT_ALLOC, 0, 0));            // zero size takes first entry
		dir_rows.push_back(mk(ACT_ALLOC, 256, 0));
		dir_rows.push_back(mk(ACT_FREE, 32'hFFFF_FFFF, ADDR_MAX - 48'h3F));
		dir_rows.push_back(mk(ACT_FREE, 32'hFFFF_FFFF, ADDR_MAX - 48'h3F)); // extent past 2^48, equal base
		dir_rows.push_back(mk(ACT_RESET, 0, 0, 1, 0, ST_OK));
		dir_rows.push_back(mk(ACT_ALLOC, 64, 0));
		foreach (dir_rows[i])
			send_word(dir_rows[i].act, dir_rows[i].sz, dir_rows[i].ad,
				dir_rows[i].fixed, dir_rows[i].grant);
		// fill the table with isolated extents; those past its capacity are refused as full
		for (int k = 0; k < NFREE + 2; k++)
			send_word(ACT_FREE, 64, 48'h80000 + 48'(k) * 48'h1000, 0, '0);
		drain();

		// region at the top of the address space, end past 2^48
		write_reg(IDX_BASE, ADDR_MAX - 48'hFFF);
		write_reg(IDX_SIZE, ADDR_MAX);
		send_word(ACT_ALLOC, 4096, 0, 0, '0);
		send_word(ACT_RESET, 0, 0, 0, '0);
		send_word(ACT_ALLOC, 4032, 0, 0, '0);
		drain();

		// random phases over several region settings
		write_reg(IDX_BASE, 48'h4000_0000);
		write_reg(IDX_SIZE, 48'h40000);
		random_phase(RAND_WORDS / 2);
		drain();
		write_reg(IDX_SIZE, ADDR_MAX);
		write_reg(IDX_BASE, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0);
		random_phase(RAND_WORDS / 3);
		drain();
		write_reg(IDX_BASE, 0);
		write_reg(IDX_SIZE, 48'h2000);
		mixed_idle = 0;
		random_phase(RAND_WORDS / 6);

		drain();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/wafl_pkg.sv
rtl/wafl_cell.sv
rtl/watermark_allocator_free_list.sv
rtl/wafl_checker.sv
test/testbench.sv
